// ===== rtl/core/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator.
// Holds sizes, request and status codes, and the shared payload and control types.
// No dependencies.
`default_nettype none

package bpfa_pkg;

	localparam int MAX_PAGES = 65536;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS = 32;
	localparam int BIT_W = 5;
	localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int LIM_W = $clog2(MAX_PAGES + 1);
	localparam int RANGE_W = 21;
	localparam int CFG_W = 17;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 17'd65536;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_RESERVE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [7:0] KIND_USABLE = 8'd1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [31:0] base_addr;
		logic [31:0] region_len;
		logic [7:0] region_kind;
		logic [31:0] end_addr;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] page_addr;
	} rsp_t;

	typedef struct packed {
		logic alloc;
		logic set;
		logic [WIDX_W-1:0] word;
		logic [WIDX_W-1:0] first_w;
		logic [BIT_W-1:0] first_lo;
		logic [WIDX_W-1:0] last_w;
		logic [BIT_W-1:0] last_lo;
	} wu_ctl_t;

	typedef struct packed {
		logic found;
		logic [BIT_W-1:0] bit_idx;
		logic [WORD_BITS-1:0] wdata;
	} wu_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_page_frame_allocator_top.sv =====
// Top level of the bitmap page frame allocator: request sequencer, bitmap memory
// and result register. Uses bpfa_pkg, bpfa_ram and bpfa_word_unit.
//
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   bpfa_pkg::req_t
// rsp       out        rsp_valid / rsp_ready   bpfa_pkg::rsp_t
// cfg       in         cfg_wr_en               cfg_wr_data (frame count)
//
// After reset a clearing pass writes every bitmap word to all used, one word a
// cycle, over all WORD_COUNT words (2048); no request is accepted meanwhile.
// A request walks the bitmap one word a cycle, reading and writing back through
// separate memory ports: allocate until a free page is found or the limit is hit,
// a range request from first to last word. Rejected or empty requests skip the walk.
// A new request is accepted while a result waits; a stalled result holds the next one.
`default_nettype none

module bitmap_page_frame_allocator_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire bpfa_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output bpfa_pkg::rsp_t rsp,
	input wire logic cfg_wr_en,
	input wire logic [bpfa_pkg::CFG_W-1:0] cfg_wr_data
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	localparam int WIDX_W = bpfa_pkg::WIDX_W;
	localparam int RANGE_W = bpfa_pkg::RANGE_W;
	localparam int LIM_W = bpfa_pkg::LIM_W;
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(bpfa_pkg::WORD_COUNT - 1);

	logic [2:0] state_q;
	logic [WIDX_W-1:0] clr_q;
	logic [bpfa_pkg::CFG_W-1:0] cfg_q;

	logic alloc_q;
	logic free_q;
	logic set_q;
	logic skip_q;
	logic [RANGE_W-1:0] first_q;
	logic [RANGE_W-1:0] raw_stop_q;
	logic [RANGE_W-1:0] stopm1_q;

	logic [WIDX_W-1:0] rd_w_q;
	logic issuing_q;
	logic valid_s1;
	logic [WIDX_W-1:0] w_s1;

	logic [1:0] res_status_q;
	logic [31:0] res_addr_q;
	logic rsp_valid_q;
	bpfa_pkg::rsp_t rsp_q;

	logic [LIM_W-1:0] lim;
	logic [RANGE_W-1:0] lim_r;
	logic [RANGE_W-1:0] stop_c;
	logic [32:0] region_sum;
	logic [32:0] end_sum;
	logic [RANGE_W-1:0] base_page;

	logic ram_we;
	logic [WIDX_W-1:0] ram_waddr;
	logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata;
	logic ram_re;
	logic [bpfa_pkg::WORD_BITS-1:0] ram_rdata;

	bpfa_pkg::wu_ctl_t wu_ctl;
	bpfa_pkg::wu_res_t wu_res;
	logic walk_done;

	assign lim = (32'(cfg_q) > 32'(bpfa_pkg::MAX_PAGES)) ? LIM_W'(bpfa_pkg::MAX_PAGES)
		: LIM_W'(cfg_q);
	assign lim_r = RANGE_W'(lim);
	assign stop_c = (raw_stop_q > lim_r) ? lim_r : raw_stop_q;
	assign region_sum = {1'b0, req.base_addr} + {1'b0, req.region_len};
	assign end_sum = {1'b0, req.end_addr} + 33'(bpfa_pkg::PAGE_BYTES - 1);
	assign base_page = RANGE_W'(req.base_addr[31:bpfa_pkg::PAGE_SHIFT]);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign wu_ctl.alloc = alloc_q;
	assign wu_ctl.set = set_q;
	assign wu_ctl.word = w_s1;
	assign wu_ctl.first_w = first_q[WIDX_W+4:5];
	assign wu_ctl.first_lo = first_q[4:0];
	assign wu_ctl.last_w = stopm1_q[WIDX_W+4:5];
	assign wu_ctl.last_lo = stopm1_q[4:0];

	bpfa_word_unit u_word_unit (
		.ctl(wu_ctl),
		.rdata(ram_rdata),
		.res(wu_res)
	);

	assign walk_done = valid_s1 && ((alloc_q && wu_res.found) || (w_s1 == wu_ctl.last_w));

	assign ram_re = (state_q == S_WALK) && issuing_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = w_s1;
		ram_wdata = wu_res.wdata;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '1;
		end else if (state_q == S_WALK && valid_s1) begin
			ram_we = !alloc_q || wu_res.found;
		end
	end

	bpfa_ram #(
		.WIDTH(bpfa_pkg::WORD_BITS),
		.DEPTH(bpfa_pkg::WORD_COUNT)
	) u_bitmap (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en(ram_re),
		.rd_addr(rd_w_q),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bpfa_pkg::FRAME_COUNT_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			issuing_q <= 1'b0;
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (skip_q) begin
						state_q <= S_FIN;
					end else if (first_q >= stop_c) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK;
						issuing_q <= 1'b1;
					end
				end
				S_WALK: begin
					if (walk_done) begin
						issuing_q <= 1'b0;
						valid_s1 <= 1'b0;
						state_q <= S_FIN;
					end else if (issuing_q) begin
						valid_s1 <= 1'b1;
						issuing_q <= (rd_w_q != wu_ctl.last_w);
					end else begin
						valid_s1 <= 1'b0;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				alloc_q <= (req.req_type == bpfa_pkg::REQ_ALLOC);
				free_q <= (req.req_type == bpfa_pkg::REQ_FREE);
				set_q <= (req.req_type == bpfa_pkg::REQ_RESERVE);
				skip_q <= (req.req_type == bpfa_pkg::REQ_RELEASE)
					&& (req.region_kind != bpfa_pkg::KIND_USABLE);
				case (req.req_type)
					bpfa_pkg::REQ_ALLOC: begin
						first_q <= '0;
						raw_stop_q <= lim_r;
					end
					bpfa_pkg::REQ_FREE: begin
						first_q <= base_page;
						raw_stop_q <= base_page + 1'b1;
					end
					bpfa_pkg::REQ_RELEASE: begin
						first_q <= base_page;
						raw_stop_q <= region_sum[32:bpfa_pkg::PAGE_SHIFT];
					end
					default: begin
						first_q <= base_page;
						raw_stop_q <= end_sum[32:bpfa_pkg::PAGE_SHIFT];
					end
				endcase
			end
			S_SETUP: begin
				stopm1_q <= stop_c - 1'b1;
				rd_w_q <= first_q[WIDX_W+4:5];
				res_addr_q <= '0;
				if (!skip_q && first_q >= stop_c) begin
					res_status_q <= free_q ? bpfa_pkg::ST_RANGE
						: (alloc_q ? bpfa_pkg::ST_NO_FREE : bpfa_pkg::ST_OK);
				end else begin
					res_status_q <= bpfa_pkg::ST_OK;
				end
			end
			S_WALK: begin
				if (issuing_q) begin
					w_s1 <= rd_w_q;
					rd_w_q <= rd_w_q + 1'b1;
				end
				if (walk_done) begin
					if (alloc_q && wu_res.found) begin
						res_status_q <= bpfa_pkg::ST_OK;
						res_addr_q <= 32'({w_s1, wu_res.bit_idx}) << bpfa_pkg::PAGE_SHIFT;
					end else if (alloc_q) begin
						res_status_q <= bpfa_pkg::ST_NO_FREE;
						res_addr_q <= '0;
					end else begin
						res_status_q <= bpfa_pkg::ST_OK;
						res_addr_q <= '0;
					end
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status <= res_status_q;
					rsp_q.page_addr <= res_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != rd_w_q))
		else $error("Bitmap read and write hit the same word in one cycle.");

	a_s1_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == S_WALK))
		else $error("Word unit stage is valid outside the walk.");

	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != bpfa_pkg::ST_OK) |-> (rsp_q.page_addr == '0))
		else $error("A failed request returned a nonzero page address.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.status == bpfa_pkg::ST_OK || rsp_q.status == bpfa_pkg::ST_NO_FREE
			|| rsp_q.status == bpfa_pkg::ST_RANGE))
		else $error("Result transaction carries an undefined status.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bpfa_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bpfa_word_unit.sv =====
// Shared word unit: masks one bitmap word to the active page range, finds the
// lowest free page in it and forms the word to write back. Uses bpfa_pkg.
`default_nettype none

module bpfa_word_unit (
	input wire bpfa_pkg::wu_ctl_t ctl,
	input wire logic [bpfa_pkg::WORD_BITS-1:0] rdata,
	output bpfa_pkg::wu_res_t res
);

	logic [bpfa_pkg::WORD_BITS-1:0] lo_mask;
	logic [bpfa_pkg::WORD_BITS-1:0] hi_mask;
	logic [bpfa_pkg::WORD_BITS-1:0] mask;
	logic [bpfa_pkg::WORD_BITS-1:0] free_bits;
	logic [bpfa_pkg::BIT_W-1:0] low_bit;

	always_comb begin
		lo_mask = '1;
		hi_mask = '1;
		if (ctl.word == ctl.first_w) begin
			lo_mask = {bpfa_pkg::WORD_BITS{1'b1}} << ctl.first_lo;
		end
		if (ctl.word == ctl.last_w) begin
			hi_mask = {bpfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - ctl.last_lo);
		end
		mask = lo_mask & hi_mask;
		free_bits = ~rdata & mask;

		low_bit = '0;
		for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				low_bit = bpfa_pkg::BIT_W'(i);
			end
		end

		res.found = |free_bits;
		res.bit_idx = low_bit;
		if (ctl.alloc) begin
			res.wdata = rdata | ({{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << low_bit);
		end else if (ctl.set) begin
			res.wdata = rdata | mask;
		end else begin
			res.wdata = rdata & ~mask;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_bitmap_page_frame_allocator_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_page_frame_allocator_top: directed table, then random
// request streams over several page limits, checked against a behavioral page bitmap.
// Depends on bpfa_pkg and the allocator RTL.

module tb_bitmap_page_frame_allocator_top;

	localparam int DIRECTED_ROWS = 27;
	localparam int PHASES = 5;
	localparam longint CYCLE_LIMIT = 10_000_000;
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		bpfa_pkg::req_t item;
		logic known;
		bpfa_pkg::rsp_t want;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bpfa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bpfa_pkg::rsp_t rsp;
	logic cfg_wr_en = 1'b0;
	logic [bpfa_pkg::CFG_W-1:0] cfg_wr_data = '0;

	bit page_used [bpfa_pkg::MAX_PAGES];
	logic [bpfa_pkg::CFG_W-1:0] frame_count_cfg = bpfa_pkg::FRAME_COUNT_RESET;
	bpfa_pkg::rsp_t pending_outcomes [$];
	plan_t plan [DIRECTED_ROWS];

	int unsigned phase_pages [PHASES] = '{0, 1, 1000, 131071, 300};
	int unsigned phase_items [PHASES] = '{20, 30, 330, 330, 330};
	int unsigned phase_send_idle [PHASES] = '{27, 27, 27, 84, 0};
	int unsigned phase_recv_idle [PHASES] = '{84, 84, 84, 27, 0};

	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 84;
	int unsigned mismatch_count = 0;
	int unsigned checked_count = 0;
	int unsigned no_free_count = 0;
	int unsigned sent_by_kind [4] = '{0, 0, 0, 0};
	int unsigned results_seen = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	longint cycle_count = 0;
	bpfa_pkg::rsp_t oldest;

	bitmap_page_frame_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic plan_t step(logic [1:0] kind_of_req, logic [31:0] base, logic [31:0] len,
			logic [7:0] region, logic [31:0] stop_addr, logic known, logic [1:0] status,
			logic [31:0] addr);
		plan_t row;
		row.item.req_type = kind_of_req;
		row.item.base_addr = base;
		row.item.region_len = len;
		row.item.region_kind = region;
		row.item.end_addr = stop_addr;
		row.known = known;
		row.want.status = status;
		row.want.page_addr = addr;
		return row;
	endfunction

	function automatic void mark_pages(longint unsigned first, longint unsigned stop,
			int unsigned lim, bit used);
		longint unsigned p;
		if (stop > 64'(lim)) begin
			stop = 64'(lim);
		end
		for (p = first; p < stop; p++) begin
			page_used[p] = used;
		end
	endfunction

	function automatic bpfa_pkg::rsp_t apply_page_request(bpfa_pkg::req_t r);
		bpfa_pkg::rsp_t o;
		int unsigned lim;
		longint unsigned p;
		bit found;
		o.status = bpfa_pkg::ST_OK;
		o.page_addr = '0;
		found = 1'b0;
		lim = (32'(frame_count_cfg) > 32'(bpfa_pkg::MAX_PAGES)) ? 32'(bpfa_pkg::MAX_PAGES)
			: 32'(frame_count_cfg);
		case (r.req_type)
			bpfa_pkg::REQ_ALLOC: begin
				for (p = 0; p < 64'(lim) && !found; p++) begin
					if (!page_used[p]) begin
						page_used[p] = 1'b1;
						o.page_addr = 32'(p) << bpfa_pkg::PAGE_SHIFT;
						found = 1'b1;
					end
				end
				if (!found) begin
					o.status = bpfa_pkg::ST_NO_FREE;
				end
			end
			bpfa_pkg::REQ_FREE: begin
				p = 64'(r.base_addr >> bpfa_pkg::PAGE_SHIFT);
				if (p >= 64'(lim)) begin
					o.status = bpfa_pkg::ST_RANGE;
				end else begin
					page_used[p] = 1'b0;
				end
			end
			bpfa_pkg::REQ_RELEASE: begin
				if (r.region_kind == bpfa_pkg::KIND_USABLE) begin
					mark_pages(64'(r.base_addr >> bpfa_pkg::PAGE_SHIFT),
						({32'd0, r.base_addr} + {32'd0, r.region_len}) >> bpfa_pkg::PAGE_SHIFT,
						lim, 1'b0);
				end
			end
			default: begin
				mark_pages(64'(r.base_addr >> bpfa_pkg::PAGE_SHIFT),
					({32'd0, r.end_addr} + 64'(bpfa_pkg::PAGE_BYTES - 1))
					>> bpfa_pkg::PAGE_SHIFT, lim, 1'b1);
			end
		endcase
		return o;
	endfunction

	function automatic bpfa_pkg::req_t random_request(int unsigned lim);
		bpfa_pkg::req_t r;
		int unsigned win;
		int unsigned pick;
		int unsigned pg;
		int unsigned npg;
		r.req_type = 2'($urandom_range(3));
		r.base_addr = $urandom;
		r.region_len = $urandom;
		r.region_kind = 8'($urandom);
		r.end_addr = $urandom;
		if ($urandom_range(99) < 10) begin
			return r;
		end
		win = ((lim < 480) ? lim : 480) + 32;
		pick = $urandom_range(99);
		pg = $urandom_range(win - 1);
		npg = $urandom_range(40);
		r.base_addr = (32'(pg) << bpfa_pkg::PAGE_SHIFT)
			| 32'($urandom_range(bpfa_pkg::PAGE_BYTES - 1));
		if (pick < 30) begin
			r.req_type = bpfa_pkg::REQ_ALLOC;
		end else if (pick < 55) begin
			r.req_type = bpfa_pkg::REQ_FREE;
		end else if (pick < 80) begin
			r.req_type = bpfa_pkg::REQ_RELEASE;
			r.region_len = (32'(npg) << bpfa_pkg::PAGE_SHIFT)
				| 32'($urandom_range(bpfa_pkg::PAGE_BYTES - 1));
			if ($urandom_range(3) != 0) begin
				r.region_kind = bpfa_pkg::KIND_USABLE;
			end
		end else begin
			r.req_type = bpfa_pkg::REQ_RESERVE;
			if ($urandom_range(9) == 0) begin
				r.end_addr = r.base_addr - 32'($urandom_range(3 * bpfa_pkg::PAGE_BYTES));
			end else begin
				r.end_addr = r.base_addr + (32'(npg) << bpfa_pkg::PAGE_SHIFT)
					+ 32'($urandom_range(bpfa_pkg::PAGE_BYTES - 1));
			end
		end
		return r;
	endfunction

	task automatic send_request(input bpfa_pkg::req_t item, input logic known,
			input bpfa_pkg::rsp_t typed);
		bpfa_pkg::rsp_t outcome;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		outcome = apply_page_request(item);
		if (outcome.status == bpfa_pkg::ST_NO_FREE) begin
			no_free_count++;
		end
		sent_by_kind[item.req_type]++;
		pending_outcomes.push_back(known ? typed : outcome);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_frame_count(input logic [bpfa_pkg::CFG_W-1:0] value);
		drain_results();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frame_count_cfg = value;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
		end
		if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen == HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected transaction: status %0d page_addr %h",
						rsp.status, rsp.page_addr);
				end
			end else begin
				oldest = pending_outcomes.pop_front();
				checked_count++;
				if (rsp.status !== oldest.status || rsp.page_addr !== oldest.page_addr) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch on result %0d: expected status %0d page_addr %h,",
							checked_count, oldest.status, oldest.page_addr);
						$display("    got status %0d page_addr %h",
							rsp.status, rsp.page_addr);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_outcomes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		int ph;
		int n;
		for (i = 0; i < bpfa_pkg::MAX_PAGES; i++) begin
			page_used[i] = 1'b1;
		end
		plan = '{
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_NO_FREE, 0),
			step(bpfa_pkg::REQ_FREE, 32'hFFFF_FFFF, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_RANGE, 0),
			step(bpfa_pkg::REQ_FREE, 32'h1000_0000, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_RANGE, 0),
			step(bpfa_pkg::REQ_FREE, 32'h0FFF_F000, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0FFF_F000),
			step(bpfa_pkg::REQ_RELEASE, 0, 32'hFFFF_FFFF, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_NO_FREE, 0),
			step(bpfa_pkg::REQ_RELEASE, 32'hFFFF_F000, 32'hFFFF_FFFF, bpfa_pkg::KIND_USABLE, 0,
				1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RELEASE, 0, 32'h0000_3000, bpfa_pkg::KIND_USABLE, 0, 1'b1,
				bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0000_0000),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0000_1000),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0000_2000),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_NO_FREE, 0),
			step(bpfa_pkg::REQ_RELEASE, 0, 32'h0001_0000, 8'hFF, 0, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RELEASE, 32'h0000_0800, 32'h0000_1000, bpfa_pkg::KIND_USABLE, 0,
				1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b0, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RESERVE, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RELEASE, 0, 32'hFFFF_FFFF, bpfa_pkg::KIND_USABLE, 0, 1'b1,
				bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RESERVE, 32'h0000_5000, 0, 8'd0, 32'h0000_1001, 1'b1,
				bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0000_0000),
			step(bpfa_pkg::REQ_RESERVE, 0, 0, 8'd0, 32'h0000_0001, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b0, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RESERVE, 32'hFFFF_F000, 0, 8'd0, 32'hFFFF_FFFF, 1'b1,
				bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_RESERVE, 0, 0, 8'd0, 32'hFFFF_FFFF, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_NO_FREE, 0),
			step(bpfa_pkg::REQ_FREE, 32'h0FFF_FFFF, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 0),
			step(bpfa_pkg::REQ_ALLOC, 0, 0, 8'd0, 0, 1'b1, bpfa_pkg::ST_OK, 32'h0FFF_F000)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			send_request(plan[i].item, plan[i].known, plan[i].want);
		end
		for (ph = 0; ph < PHASES; ph++) begin
			write_frame_count(bpfa_pkg::CFG_W'(phase_pages[ph]));
			send_idle_pct = phase_send_idle[ph];
			recv_idle_pct = phase_recv_idle[ph];
			for (n = 0; n < phase_items[ph]; n++) begin
				if (n == phase_items[ph] / 2) begin
					drain_results();
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end
				send_request(random_request(
					(phase_pages[ph] > bpfa_pkg::MAX_PAGES) ? bpfa_pkg::MAX_PAGES
					: phase_pages[ph]), 1'b0, '0);
			end
		end
		drain_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests: %0d allocate, %0d free, %0d release, %0d reserve.",
			sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
			sent_by_kind[bpfa_pkg::REQ_ALLOC], sent_by_kind[bpfa_pkg::REQ_FREE],
			sent_by_kind[bpfa_pkg::REQ_RELEASE], sent_by_kind[bpfa_pkg::REQ_RESERVE]);
		$display("Checked %0d results over %0d page limits; %0d allocations found no free page.",
			checked_count, PHASES + 1, no_free_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches.", mismatch_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
